@@ rtl/ssd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

  localparam int SEG_W    = 8;
  localparam int ENABLE_W = 4;
  localparam int NUMBER_W = 16;
  localparam int DIGIT_W  = 4;

  typedef logic [1:0] cmd_field_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Stored digit code: blank, or one plus the hex value of the digit.
  typedef logic [4:0] code_t;

  localparam code_t CODE_BLANK = 5'd0;
  localparam code_t CODE_MAX   = 5'd16;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

  // Active-low segment patterns, indexed by stored digit code.
  localparam logic [SEG_W-1:0] PATTERNS [17] = '{
    8'hFF, 8'h82, 8'hEE, 8'h07, 8'h46, 8'h6A, 8'h52, 8'h12, 8'hE6,
    8'h02, 8'h62, 8'h22, 8'h1A, 8'h93, 8'h0E, 8'h13, 8'h33
  };

  function automatic logic [SEG_W-1:0] seg_pattern(code_t code);
    logic [SEG_W-1:0] pat;
    if (code <= CODE_MAX) begin
      pat = PATTERNS[code];
    end else begin
      pat = SEG_BLANK;
    end
    return pat;
  endfunction

  function automatic longint unsigned pow10(int n);
    longint unsigned acc;
    acc = 64'd1;
    for (int i = 0; i < n; i++) begin
      acc = acc * 64'd10;
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ssd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ssd_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] number;
  logic        keep_zeros;

  modport source (output valid, output cmd, output number, output keep_zeros, input ready);
  modport sink   (input valid, input cmd, input number, input keep_zeros, output ready);
endinterface

interface ssd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] segment_drive;
  logic [3:0] digit_enable;

  modport source (output valid, output segment_drive, output digit_enable, input ready);
  modport sink   (input valid, input segment_drive, input digit_enable, output ready);
endinterface

interface ssd_cfg_if;
  logic valid;
  logic ready;
  logic scan_enable;

  modport source (output valid, output scan_enable, input ready);
  modport sink   (input valid, input scan_enable, output ready);
endinterface

`default_nettype wire

@@ rtl/ssd_dec_conv.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssd_dec_conv #(
  parameter int NUM_DIGITS = 4
) (
  input  logic [15:0]                      number,
  input  logic                             keep_zeros,
  output ssd_pkg::code_t [NUM_DIGITS-1:0]  codes
);
  import ssd_pkg::*;

  localparam longint unsigned LIMIT = pow10(NUM_DIGITS) - 64'd1;
  localparam logic [NUMBER_W-1:0] LIMIT16 =
      (LIMIT > 64'd65535) ? 16'hFFFF : LIMIT[NUMBER_W-1:0];

  logic [NUMBER_W-1:0] value;
  logic [NUMBER_W-1:0] quot [NUM_DIGITS+1];
  logic [DIGIT_W-1:0]  digit [NUM_DIGITS];
  logic [NUM_DIGITS-1:0] blank;

  assign value   = (number > LIMIT16) ? LIMIT16 : number;
  assign quot[0] = value;

  // Each quotient by a power of ten is a multiply by a rounded-up
  // reciprocal; the shift is wide enough to be exact for 16-bit values.
  for (genvar k = 1; k <= NUM_DIGITS; k++) begin : g_quot
    localparam longint unsigned DIV = pow10(k);
    localparam int              SH  = 17 + $clog2(DIV);
    localparam longint unsigned MUL = ((64'd1 << SH) + DIV - 64'd1) / DIV;
    localparam logic [17:0]     MUL18 = MUL[17:0];

    logic [63:0] prod;
    assign prod    = {48'd0, value} * {46'd0, MUL18};
    assign quot[k] = NUMBER_W'(prod >> SH);
  end

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_digit
    logic [NUMBER_W-1:0] rem_full;
    assign rem_full = quot[k] - (quot[k+1] << 3) - (quot[k+1] << 1);
    assign digit[k] = rem_full[DIGIT_W-1:0];
  end

  // Leading zeros blank from the top digit down; the ones digit always shows.
  always_comb begin
    blank = '0;
    for (int i = NUM_DIGITS - 1; i >= 1; i--) begin
      if (i == NUM_DIGITS - 1) begin
        blank[i] = !keep_zeros && (digit[i] == '0);
      end else begin
        blank[i] = blank[i+1] && (digit[i] == '0);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      codes[i] = blank[i] ? CODE_BLANK : code_t'({1'b0, digit[i]} + 5'd1);
    end
  end

endmodule

`default_nettype wire

@@ rtl/seven_segment_scan_driver.sv @@
`timescale 1ns / 1ps
`default_nettype none

// An accepted word passes through the input register, then the update stage
// that writes the digit store and the result register. Throughput: one word
// per cycle unless the result side stalls; the single update stage sets it.
// Reset (rst, synchronous, active high): all digits blank, scan position 0,
// segment and enable outputs 0, scan_enable 1, no word held.
module seven_segment_scan_driver #(
  parameter int NUM_DIGITS = 4
) (
  input  logic          clk,
  input  logic          rst,
  ssd_item_if.sink      item,
  ssd_result_if.source  result,
  ssd_cfg_if.sink       cfg
);
  import ssd_pkg::*;

  localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic                scan_enable;
  logic                stage_valid;
  cmd_t                stage_cmd;
  logic [NUMBER_W-1:0] stage_number;
  logic                stage_fill;
  code_t               store [NUM_DIGITS];
  logic [POS_W-1:0]    scan_pos;
  logic [POS_W-1:0]    scan_pos_next;
  logic [SEG_W-1:0]    seg_drive;
  logic [ENABLE_W-1:0] enable_drive;
  logic [ENABLE_W-1:0] enable_next;
  logic                out_valid;

  logic  advance;
  logic  fire;
  code_t [NUM_DIGITS-1:0] set_codes;

  ssd_dec_conv #(.NUM_DIGITS(NUM_DIGITS)) u_conv (
    .number     (stage_number),
    .keep_zeros (stage_fill),
    .codes      (set_codes)
  );

  assign advance    = !out_valid || result.ready;
  assign fire       = stage_valid && advance;
  assign item.ready = !stage_valid || advance;
  assign cfg.ready  = 1'b1;

  assign result.valid         = out_valid;
  assign result.segment_drive = seg_drive;
  assign result.digit_enable  = enable_drive;

  assign scan_pos_next = (scan_pos == POS_W'(NUM_DIGITS - 1)) ? '0 : POS_W'(scan_pos + 1'b1);

  // Digits beyond the enable width have no enable bit.
  always_comb begin
    enable_next = '0;
    for (int i = 0; i < ENABLE_W; i++) begin
      if ((i < NUM_DIGITS) && (int'(scan_pos) == i)) begin
        enable_next[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage_cmd    <= cmd_t'(item.cmd);
      stage_number <= item.number;
      stage_fill   <= item.keep_zeros;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_enable  <= 1'b1;
      stage_valid  <= 1'b0;
      out_valid    <= 1'b0;
      scan_pos     <= '0;
      seg_drive    <= '0;
      enable_drive <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        store[i] <= CODE_BLANK;
      end
    end else begin
      if (cfg.valid && cfg.ready) begin
        scan_enable <= cfg.scan_enable;
      end
      if (item.ready) begin
        stage_valid <= item.valid;
      end
      if (advance) begin
        out_valid <= stage_valid;
      end
      if (fire) begin
        case (stage_cmd)
          CMD_TICK: begin
            if (scan_enable) begin
              seg_drive    <= seg_pattern(store[scan_pos]);
              enable_drive <= enable_next;
              scan_pos     <= scan_pos_next;
            end
          end
          CMD_SET: begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
              store[i] <= set_codes[i];
            end
          end
          CMD_CLEAR: begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
              store[i] <= CODE_BLANK;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ssd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssd_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] segment_drive,
  input logic [3:0] digit_enable
);

  // At most one digit is ever lit.
  a_enable_onehot: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0(digit_enable))
    else $error("more than one digit enabled");

  // Right after reset nothing is offered and all digits are dark.
  a_reset_clean: assert property (@(posedge clk)
    $past(rst) |-> (!result_valid && (digit_enable == 4'd0)))
    else $error("result not clean after reset");

  // The driven outputs only move together with a new result word.
  a_change_needs_word: assert property (@(posedge clk) disable iff (rst)
    (!$stable(digit_enable) || !$stable(segment_drive)) |-> result_valid)
    else $error("outputs changed without a result word");

  // A stalled result word holds its contents.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(segment_drive) && $stable(digit_enable)))
    else $error("stalled result word changed");

  // An empty pipeline always takes a word.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && !result_valid && $past(!item_valid) && $past(!result_valid))
      |-> item_ready)
    else $error("input stalled while pipeline empty");

endmodule

bind seven_segment_scan_driver ssd_checker u_ssd_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .segment_drive (result.segment_drive),
  .digit_enable  (result.digit_enable)
);

`default_nettype wire
